// ===== hdl/ttsp_pkg.sv =====
// Shared types and constants for the translucent texture span pixel block.
`default_nettype none

package ttsp_pkg;

    // Default texture address width; the texture store holds 2**bits texels.
    localparam int TEX_ADDR_BITS_DEF = 16;

    // Item kinds carried on the input tuser field.
    typedef enum logic [2:0] {
        KIND_LOAD_TEXEL = 3'd0,
        KIND_LOAD_TABLE = 3'd1,
        KIND_SET_PRESENT = 3'd2,
        KIND_SPAN_START = 3'd3,
        KIND_PIXEL = 3'd4
    } kind_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WIDTH_MASK = 3'd0;
    localparam logic [2:0] CFG_HEIGHT_MASK = 3'd1;
    localparam logic [2:0] CFG_WIDTH_LOG = 3'd2;
    localparam logic [2:0] CFG_OPAQUE_MODE = 3'd3;
    localparam logic [2:0] CFG_U_STEP = 3'd4;
    localparam logic [2:0] CFG_V_STEP = 3'd5;

    // Result queue sizing: the two pipeline stages, the beat waiting at the output
    // and one spare slot keep the input open at full rate.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_BITS = FIFO_CNT_BITS + 1;

    // Per-beat work issued to the shading pipeline.
    typedef struct packed {
        logic        tex_we;
        logic        tab_we;
        logic        pres_we;
        logic        pix_valid;
        logic [15:0] load_address;
        logic [7:0]  load_value;
        logic [7:0]  dest_pixel;
    } issue_t;

    // One shaded pixel.
    typedef struct packed {
        logic       written;
        logic [7:0] pixel;
    } pix_result_t;

endpackage

`default_nettype wire

// ===== hdl/ttsp_addr_gen.sv =====
// Configuration registers, u/v accumulators and texel address generation.
`default_nettype none

module ttsp_addr_gen #(
    parameter int TEX_ADDR_BITS = ttsp_pkg::TEX_ADDR_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [31:0]              cfg_data,
    input  wire logic                     span_start,
    input  wire logic                     pixel_step,
    input  wire logic signed [31:0]       start_u,
    input  wire logic signed [31:0]       start_v,
    output logic [TEX_ADDR_BITS-1:0]      tex_addr,
    output logic                          opaque_mode
);

    logic [15:0] width_mask_reg;
    logic [15:0] height_mask_reg;
    logic [4:0]  width_log_reg;
    logic        opaque_mode_reg;
    logic [31:0] u_step_reg;
    logic [31:0] v_step_reg;
    logic [31:0] u_accum_reg;
    logic [31:0] v_accum_reg;

    logic [15:0]              row;
    logic [15:0]              col;
    logic [TEX_ADDR_BITS-1:0] row_shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_mask_reg  <= '0;
            height_mask_reg <= '0;
            width_log_reg   <= '0;
            opaque_mode_reg <= 1'b0;
            u_step_reg      <= '0;
            v_step_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ttsp_pkg::CFG_WIDTH_MASK:  width_mask_reg  <= cfg_data[15:0];
                ttsp_pkg::CFG_HEIGHT_MASK: height_mask_reg <= cfg_data[15:0];
                ttsp_pkg::CFG_WIDTH_LOG:   width_log_reg   <= cfg_data[4:0];
                ttsp_pkg::CFG_OPAQUE_MODE: opaque_mode_reg <= cfg_data[0];
                ttsp_pkg::CFG_U_STEP:      u_step_reg      <= cfg_data;
                ttsp_pkg::CFG_V_STEP:      v_step_reg      <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // The accumulators step after each pixel; the address uses the value before the step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_accum_reg <= '0;
            v_accum_reg <= '0;
        end
        else if (span_start)
        begin
            u_accum_reg <= start_u;
            v_accum_reg <= start_v;
        end
        else if (pixel_step)
        begin
            u_accum_reg <= u_accum_reg + u_step_reg;
            v_accum_reg <= v_accum_reg + v_step_reg;
        end
    end

    // Truncating the row before the shift is safe since the shift only moves bits upward.
    always_comb
    begin
        row         = v_accum_reg[31:16] & height_mask_reg;
        col         = u_accum_reg[31:16] & width_mask_reg;
        row_shifted = TEX_ADDR_BITS'(row) << width_log_reg;
        tex_addr    = row_shifted + TEX_ADDR_BITS'(col);
    end

    assign opaque_mode = opaque_mode_reg;

endmodule

`default_nettype wire

// ===== hdl/ttsp_shade.sv =====
// Texture store, translucency tables, present flags and the shading pipeline.
`default_nettype none

module ttsp_shade #(
    parameter int TEX_ADDR_BITS = ttsp_pkg::TEX_ADDR_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ttsp_pkg::issue_t         issue,
    input  wire logic [TEX_ADDR_BITS-1:0] tex_addr,
    input  wire logic                     opaque_mode,
    output logic [1:0]                    in_flight,
    output logic                          res_valid,
    output ttsp_pkg::pix_result_t         res
);

    localparam int TEX_DEPTH = 2 ** TEX_ADDR_BITS;

    logic [7:0]   tex_mem [TEX_DEPTH];
    logic [7:0]   tab_mem [65536];
    logic [255:0] present_reg;

    logic [7:0] tex_q_reg;
    logic [7:0] tab_q_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_dest_reg;
    logic       s2_valid_reg;
    logic [7:0] s2_dest_reg;
    logic [7:0] s2_texel_reg;
    logic       s2_present_reg;

    logic transparent;

    // Loads and pixel reads enter at the same point, so the store sees them in order.
    always_ff @(posedge clk)
    begin
        if (issue.tex_we)
        begin
            tex_mem[TEX_ADDR_BITS'(issue.load_address)] <= issue.load_value;
        end
        if (issue.pix_valid)
        begin
            tex_q_reg <= tex_mem[tex_addr];
        end
    end

    // A table write landing in the same cycle as a read belongs to a later item,
    // so the read must return the old entry.
    always_ff @(posedge clk)
    begin
        if (issue.tab_we)
        begin
            tab_mem[issue.load_address] <= issue.load_value;
        end
        if (s1_valid_reg)
        begin
            tab_q_reg <= tab_mem[{tex_q_reg, s1_dest_reg}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue.pres_we)
            begin
                present_reg[issue.load_address[7:0]] <= issue.load_value[0];
            end
            s1_valid_reg <= issue.pix_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dest_reg    <= issue.dest_pixel;
        s2_dest_reg    <= s1_dest_reg;
        s2_texel_reg   <= tex_q_reg;
        s2_present_reg <= present_reg[tex_q_reg];
    end

    always_comb
    begin
        transparent = !opaque_mode && (s2_texel_reg == 8'd0);
        res.written = !transparent;
        if (transparent)
        begin
            res.pixel = s2_dest_reg;
        end
        else if (s2_present_reg)
        begin
            res.pixel = tab_q_reg;
        end
        else
        begin
            res.pixel = s2_texel_reg;
        end
    end

    assign res_valid = s2_valid_reg;
    assign in_flight = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

`default_nettype wire

// ===== hdl/ttsp_out_fifo.sv =====
// Small result queue that decouples the shading pipeline from the output stream.
`default_nettype none

module ttsp_out_fifo (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire ttsp_pkg::pix_result_t              push_data,
    input  wire logic                               pop_ready,
    output logic                                    pop_valid,
    output ttsp_pkg::pix_result_t                   pop_data,
    output logic [ttsp_pkg::FIFO_CNT_BITS-1:0]      count
);

    ttsp_pkg::pix_result_t mem [ttsp_pkg::FIFO_DEPTH];

    logic [ttsp_pkg::FIFO_PTR_BITS-1:0] head_reg;
    logic [ttsp_pkg::FIFO_PTR_BITS-1:0] tail_reg;
    logic [ttsp_pkg::FIFO_CNT_BITS-1:0] count_reg;
    logic [ttsp_pkg::FIFO_CNT_BITS-1:0] count_next;
    logic                               pop;

    assign pop = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[head_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== hdl/translucent_texture_span_pixel.sv =====
// Top level of the translucent affine texture span pixel shader.
`default_nettype none

// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    tuser: kind; tdata: load and pixel fields
// m_*       out        m_tvalid / m_tready    tdata: pixel_out; tuser: pixel_written
// cfg_*     in         cfg_valid / cfg_ready  cfg_index selects register, cfg_data value
//
// The block takes one beat per cycle while s_tready is high; a pixel result passes the
// texture read and then the table read before it is written into the result queue,
// from which it can leave.
// Reset clears the configuration, the accumulators and the 256 table-present flags;
// the texture and table memories hold whatever was last written.
// Output stalls fill a four-entry result queue; input is held back only when the
// queue plus the pixels still in the pipeline would exceed its depth.
// Configuration writes are always taken and must only arrive while the block is idle.

module translucent_texture_span_pixel #(
    parameter int TEX_ADDR_BITS = ttsp_pkg::TEX_ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: load_address[15:0], load_value[23:16], start_u[55:24],
    // start_v[87:56], dest_pixel[95:88].
    input  wire logic [95:0] s_tdata,
    // Fields from bit 0: kind[2:0].
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: pixel_out[7:0].
    output logic [7:0]       m_tdata,
    // Fields from bit 0: pixel_written[0].
    output logic [0:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic                              accept;
    ttsp_pkg::issue_t                  issue;
    logic [TEX_ADDR_BITS-1:0]          tex_addr;
    logic                              opaque_mode;
    logic [1:0]                        in_flight;
    logic                              res_valid;
    ttsp_pkg::pix_result_t             res;
    ttsp_pkg::pix_result_t             out_data;
    logic [ttsp_pkg::FIFO_CNT_BITS-1:0] fifo_count;
    logic [ttsp_pkg::OCC_BITS-1:0]     occupancy;

    // Every pixel in the pipeline already holds a queue slot, so the queue never overflows.
    assign occupancy = ttsp_pkg::OCC_BITS'(fifo_count) + ttsp_pkg::OCC_BITS'(in_flight);
    assign s_tready  = occupancy < ttsp_pkg::OCC_BITS'(ttsp_pkg::FIFO_DEPTH);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Kinds outside the defined set decode to no action and no result.
    always_comb
    begin
        issue.tex_we       = accept && (s_tuser == ttsp_pkg::KIND_LOAD_TEXEL);
        issue.tab_we       = accept && (s_tuser == ttsp_pkg::KIND_LOAD_TABLE);
        issue.pres_we      = accept && (s_tuser == ttsp_pkg::KIND_SET_PRESENT);
        issue.pix_valid    = accept && (s_tuser == ttsp_pkg::KIND_PIXEL);
        issue.load_address = s_tdata[15:0];
        issue.load_value   = s_tdata[23:16];
        issue.dest_pixel   = s_tdata[95:88];
    end

    ttsp_addr_gen #(
        .TEX_ADDR_BITS(TEX_ADDR_BITS)
    ) u_addr_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .span_start (accept && (s_tuser == ttsp_pkg::KIND_SPAN_START)),
        .pixel_step (issue.pix_valid),
        .start_u    (s_tdata[55:24]),
        .start_v    (s_tdata[87:56]),
        .tex_addr   (tex_addr),
        .opaque_mode(opaque_mode)
    );

    ttsp_shade #(
        .TEX_ADDR_BITS(TEX_ADDR_BITS)
    ) u_shade (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .tex_addr   (tex_addr),
        .opaque_mode(opaque_mode),
        .in_flight  (in_flight),
        .res_valid  (res_valid),
        .res        (res)
    );

    ttsp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (m_tready),
        .pop_valid (m_tvalid),
        .pop_data  (out_data),
        .count     (fifo_count)
    );

    assign m_tdata    = out_data.pixel;
    assign m_tuser[0] = out_data.written;

endmodule

`default_nettype wire

// ===== test/translucent_texture_span_pixel_test.sv =====
// Self-checking testbench for the translucent texture span pixel shader.
module translucent_texture_span_pixel_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The texture store size follows the block's default address width.
    localparam int TEX_BITS = ttsp_pkg::TEX_ADDR_BITS_DEF;
    localparam int TEX_DEPTH = 1 << TEX_BITS;

    // Kinds above the last defined one are accepted by the block and dropped.
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST = 3'd7;

    // Cycles without any accepted beat on any channel before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off.
    localparam int STALL_LIMIT = 3000;

    // Cycles to let loads drain from the pipeline once the last pixel has come out.
    localparam int PIPE_SETTLE = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    translucent_texture_span_pixel #(
        .TEX_ADDR_BITS(TEX_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the block's state. The memories carry a written flag
    // per entry so that stimulus never reads an entry that holds nothing.
    // ------------------------------------------------------------------
    logic [7:0]  tex_mem [TEX_DEPTH];
    bit          tex_seen [TEX_DEPTH];
    logic [7:0]  blend_mem [65536];
    bit          blend_seen [65536];
    bit          blend_on [256];
    logic [31:0] u_acc = '0;
    logic [31:0] v_acc = '0;

    // Shadow copy of the configuration registers, at their reset values.
    logic [15:0] wmask = '0;
    logic [15:0] hmask = '0;
    logic [4:0]  wlog = '0;
    logic        opaque = 1'b0;
    logic [31:0] u_inc = '0;
    logic [31:0] v_inc = '0;

    // Shaded pixels that the block still owes us, oldest first.
    ttsp_pkg::pix_result_t pixels_due [$];
    ttsp_pkg::pix_result_t oldest;

    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    // Random idling on both channels; cleared for stretches of full-rate traffic.
    bit idle_on = 1'b1;
    // Receiver wait before its next beat, and a long hold-off requested by a test.
    int rx_wait = 0;
    int rx_hold = 0;

    function automatic logic [95:0] noise();
        return {$urandom, $urandom, $urandom};
    endfunction

    // Texels are zero often enough that the transparent path gets plenty of traffic.
    function automatic logic [7:0] random_texel();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    // Address of the texel the next pixel beat will fetch, from the current u and v.
    function automatic logic [TEX_BITS-1:0] texel_index();
        logic [63:0] row;
        logic [63:0] col;
        logic [63:0] sum;
        row = 64'((v_acc >> 16) & {16'd0, hmask});
        col = 64'((u_acc >> 16) & {16'd0, wmask});
        sum = (row << wlog) + col;
        return sum[TEX_BITS-1:0];
    endfunction

    // Applies one accepted input beat to the shadow state and, for a pixel,
    // queues the shaded value the block must return.
    function automatic void shade_beat(input logic [2:0] kind, input logic [95:0] data);
        logic [15:0]           addr;
        logic [7:0]            val;
        logic [7:0]            dest;
        logic [7:0]            texel;
        logic [TEX_BITS-1:0]   ta;
        ttsp_pkg::pix_result_t res;
        addr = data[15:0];
        val = data[23:16];
        dest = data[95:88];
        case (kind)
            ttsp_pkg::KIND_LOAD_TEXEL:
            begin
                tex_mem[addr[TEX_BITS-1:0]] = val;
                tex_seen[addr[TEX_BITS-1:0]] = 1'b1;
            end
            ttsp_pkg::KIND_LOAD_TABLE:
            begin
                blend_mem[addr] = val;
                blend_seen[addr] = 1'b1;
            end
            ttsp_pkg::KIND_SET_PRESENT:
            begin
                blend_on[addr[7:0]] = val[0];
            end
            ttsp_pkg::KIND_SPAN_START:
            begin
                u_acc = data[55:24];
                v_acc = data[87:56];
            end
            ttsp_pkg::KIND_PIXEL:
            begin
                ta = texel_index();
                texel = tex_mem[ta];
                if (opaque || texel != 8'h00)
                begin
                    res.written = 1'b1;
                    res.pixel = blend_on[texel] ? blend_mem[{texel, dest}] : texel;
                end
                else
                begin
                    res.written = 1'b0;
                    res.pixel = dest;
                end
                pixels_due.push_back(res);
                u_acc = u_acc + u_inc;
                v_acc = v_acc + v_inc;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch in result %0d: %s got %h expected %h",
                 results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge; returns at the falling edge after
    // its beat was taken, with tvalid still high so back-to-back beats
    // can follow directly.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [2:0] kind, input logic [95:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        shade_beat(kind, data);
        if (kind < KIND_SPARE_FIRST)
            items_sent++;
        @(negedge clk);
    endtask

    // Load-type beat: address and byte in place, every other bit random.
    task automatic send_load(input logic [2:0] kind, input logic [15:0] addr,
                             input logic [7:0] val);
        logic [95:0] data;
        data = noise();
        data[15:0] = addr;
        data[23:16] = val;
        send_beat(kind, data);
    endtask

    task automatic span_start(input logic [31:0] su, input logic [31:0] sv);
        logic [95:0] data;
        data = noise();
        data[55:24] = su;
        data[87:56] = sv;
        send_beat(ttsp_pkg::KIND_SPAN_START, data);
    endtask

    // Sends a pixel beat, first loading the texel and the table entry it will
    // read if those were never written.
    task automatic draw_pixel(input logic [7:0] dest);
        logic [TEX_BITS-1:0] ta;
        logic [7:0]          texel;
        logic [95:0]         data;
        ta = texel_index();
        if (!tex_seen[ta])
            send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'(ta), random_texel());
        texel = tex_mem[ta];
        if ((opaque || texel != 8'h00) && blend_on[texel] && !blend_seen[{texel, dest}])
            send_load(ttsp_pkg::KIND_LOAD_TABLE, {texel, dest}, 8'($urandom));
        data = noise();
        data[95:88] = dest;
        send_beat(ttsp_pkg::KIND_PIXEL, data);
    endtask

    // Stops offering beats and waits for every owed pixel, then for loads
    // that may still be in the pipeline. Returns at a falling edge.
    task automatic settle();
        s_tvalid = 1'b0;
        while (pixels_due.size() != 0) @(posedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    // One register write; cfg_valid stays high for a following write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            ttsp_pkg::CFG_WIDTH_MASK: wmask = value[15:0];
            ttsp_pkg::CFG_HEIGHT_MASK: hmask = value[15:0];
            ttsp_pkg::CFG_WIDTH_LOG: wlog = value[4:0];
            ttsp_pkg::CFG_OPAQUE_MODE: opaque = value[0];
            ttsp_pkg::CFG_U_STEP: u_inc = value;
            ttsp_pkg::CFG_V_STEP: v_inc = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    // Writes all six registers once the block is idle. Bits above each
    // register's width carry junk, which the block must drop.
    task automatic configure(input logic [15:0] wm, input logic [15:0] hm,
                             input logic [4:0] wl, input logic op,
                             input logic [31:0] us, input logic [31:0] vs);
        settle();
        write_reg(ttsp_pkg::CFG_WIDTH_MASK, {16'($urandom), wm});
        write_reg(ttsp_pkg::CFG_HEIGHT_MASK, {16'($urandom), hm});
        write_reg(ttsp_pkg::CFG_WIDTH_LOG, {27'($urandom), wl});
        write_reg(ttsp_pkg::CFG_OPAQUE_MODE, {31'($urandom), op});
        write_reg(ttsp_pkg::CFG_U_STEP, us);
        write_reg(ttsp_pkg::CFG_V_STEP, vs);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_mask();
        int lg;
        lg = $urandom_range(0, 6);
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'((1 << lg) - 1);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset all registers are zero, so every pixel reads
    // texel 0, texel value 0 is transparent, and no color has a table.
    task automatic test_reset_defaults();
        send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'h0000, 8'h00);
        draw_pixel(8'hA5);
        send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'h0000, 8'h3C);
        draw_pixel(8'h00);
    endtask

    // A 4x4 texture walked along one row: transparent texel, texel with a
    // table, plain texels, and the narrowing rules for present-flag loads.
    task automatic test_directed_cases();
        configure(16'h0003, 16'h0003, 5'd2, 1'b0, 32'h0001_0000, 32'h0000_0000);
        send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'h0000, 8'h00);
        send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'h0001, 8'hFF);
        send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'h0002, 8'h01);
        send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'h0003, 8'h80);
        send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'hFFFF, 8'h7E);
        send_load(ttsp_pkg::KIND_LOAD_TABLE, 16'hFF55, 8'hAA);
        // Only the low byte picks the color, and only bit 0 of the value counts.
        send_load(ttsp_pkg::KIND_SET_PRESENT, 16'hABFF, 8'h01);
        send_load(ttsp_pkg::KIND_SET_PRESENT, 16'h0080, 8'hFE);
        span_start(32'h0000_0000, 32'h0000_0000);
        draw_pixel(8'h55);
        draw_pixel(8'h55);
        draw_pixel(8'h00);
        draw_pixel(8'hFF);
        // Unused kinds must pass without producing anything.
        send_beat(KIND_SPARE_FIRST, noise());
        send_beat(3'd6, noise());
        send_beat(KIND_SPARE_LAST, noise());
        // In opaque mode texel 0 is drawn, first plain, then through its table.
        configure(16'h0003, 16'h0003, 5'd2, 1'b1, 32'h0000_0000, 32'h0000_0000);
        span_start(32'h0000_0000, 32'h0000_0000);
        draw_pixel(8'h12);
        send_load(ttsp_pkg::KIND_SET_PRESENT, 16'h0000, 8'h01);
        draw_pixel(8'h34);
    endtask

    // One configuration, then spans of random length mixed with loads,
    // flag changes and dropped kinds. The early phases pin the extremes.
    task automatic test_random_phase(input int phase, input int n_items);
        int          target;
        int          pick;
        int          len;
        logic [15:0] wm;
        logic [15:0] hm;
        logic [4:0]  wl;
        case (phase)
            0: configure(16'hFFFF, 16'hFFFF, 5'd31, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
            1: configure(16'hFFFF, 16'h0000, 5'd16, 1'b1, $urandom, $urandom);
            2: configure(16'h0000, 16'h0000, 5'd0, 1'b0, 32'h0000_0000, 32'h0000_0000);
            default:
            begin
                wm = pick_mask();
                hm = pick_mask();
                wl = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
                configure(wm, hm, wl, 1'($urandom),
                          32'($signed($urandom) >>> $urandom_range(8, 16)),
                          32'($signed($urandom) >>> $urandom_range(8, 16)));
            end
        endcase
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                span_start($urandom, $urandom);
                len = $urandom_range(1, 12);
                repeat (len) draw_pixel(8'($urandom));
            end
            else if (pick < 65)
                send_load(ttsp_pkg::KIND_LOAD_TEXEL, 16'($urandom), random_texel());
            else if (pick < 73)
                send_load(ttsp_pkg::KIND_LOAD_TABLE, 16'($urandom), 8'($urandom));
            else if (pick < 85)
                send_load(ttsp_pkg::KIND_SET_PRESENT, 16'($urandom), 8'($urandom));
            else if (pick < 90)
                send_beat(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), noise());
            else
                draw_pixel(8'($urandom));
        end
    endtask

    // The receiver stops for a long stretch while pixels keep coming at full
    // rate, so the result queue fills and the block must hold off its input.
    task automatic test_receiver_hold();
        settle();
        idle_on = 1'b0;
        rx_hold = 300;
        span_start($urandom, $urandom);
        repeat (40) draw_pixel(8'($urandom));
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver: a per-beat random wait, or the long hold-off when asked.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready = 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (rx_wait > 0)
        begin
            m_tready = 1'b0;
            rx_wait = rx_wait - 1;
        end
        else
            m_tready = 1'b1;
    end

    // Result checker: every accepted result beat is matched against the
    // oldest owed pixel, field by field.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_wait = idle_on ? $urandom_range(0, 4) : 0;
            results_seen++;
            if (pixels_due.size() == 0)
                report_mismatch("unexpected result, pixel_out", m_tdata, 8'h00);
            else
            begin
                oldest = pixels_due.pop_front();
                if (m_tdata !== oldest.pixel)
                    report_mismatch("pixel_out", m_tdata, oldest.pixel);
                if (m_tuser[0] !== oldest.written)
                    report_mismatch("pixel_written", {7'd0, m_tuser[0]},
                                    {7'd0, oldest.written});
            end
        end
    end

    // Watchdog: too long with no beat taken on any channel means a hang.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("translucent_texture_span_pixel_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        // Reset starts asserted and is released on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cases();
        for (int p = 0; p < 8; p++)
        begin
            // One phase runs at full rate on both sides.
            idle_on = (p != 5);
            test_random_phase(p, 150);
        end
        idle_on = 1'b1;
        test_receiver_hold();

        settle();
        if (mismatches == 0)
            $display("translucent_texture_span_pixel_test OK");
        else
            $display("translucent_texture_span_pixel_test NOT OK");
        $finish;
    end

endmodule
